>>> rtl/salru_pkg.sv
// Shared types and constants of the set-associative LRU tag lookup.
package salru_pkg;

    localparam int ADDRESS_BITS      = 32;
    localparam int BLK_W             = ADDRESS_BITS - 2;
    localparam int WAYS_MAX          = 16;
    localparam int WAY_LIMIT_LOG2    = 4;
    localparam int ACCESS_BYTE_LIMIT = 16;
    localparam int RESULT_LIMIT      = 5;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 3;

    localparam logic [CFG_IDX_W-1:0] REG_WAYS_LOG2  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_LOG2 = 2'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_UPD
    } state_t;

    // Outcome of the tag compare and victim search for one set.
    typedef struct packed {
        logic       hit;
        logic [3:0] col;
    } sel_t;

endpackage

>>> rtl/salru_row_ram.sv
// Row memory holding tag, age and valid bits of sixteen consecutive ways per row.
module salru_row_ram #(
    parameter int ROWS   = 2048,
    parameter int ROW_AW = 11,
    parameter int TAG_W  = 22
) (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [ROW_AW-1:0]           rd_addr,
    output logic [15:0][TAG_W-1:0]      rd_tag,
    output logic [15:0][3:0]            rd_age,
    output logic [15:0]                 rd_valid,
    input  logic                        wr_en,
    input  logic [ROW_AW-1:0]           wr_addr,
    input  logic [15:0][TAG_W-1:0]      wr_tag,
    input  logic [15:0][3:0]            wr_age,
    input  logic [15:0]                 wr_valid
);

    localparam int ROW_BITS = 16 * (TAG_W + 5);

    logic [ROW_BITS-1:0] mem [ROWS];
    logic [ROW_BITS-1:0] rd_row_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_valid, wr_age, wr_tag};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_row_reg <= mem[rd_addr];
        end
    end

    assign {rd_valid, rd_age, rd_tag} = rd_row_reg;

endmodule

>>> rtl/salru_way_sel.sv
// Tag compare and oldest-way search over the ways of one set within a row.
module salru_way_sel #(
    parameter int TAG_W = 22
) (
    input  logic [15:0][TAG_W-1:0] row_tag,
    input  logic [15:0][3:0]       row_age,
    input  logic [15:0]            row_valid,
    input  logic [3:0]             base_col,
    input  logic [3:0]             wmask,
    input  logic [TAG_W-1:0]       tag,
    output salru_pkg::sel_t        sel
);

    logic [15:0] in_set;
    logic [15:0] hit_vec;
    logic [4:0]  lkey [0:4][0:15];
    logic [3:0]  lidx [0:4][0:15];
    logic [3:0]  hit_col;

    always_comb
    begin
        for (int c = 0; c < 16; c++)
        begin
            in_set[c]  = ((4'(c) & ~wmask) == (base_col & ~wmask));
            hit_vec[c] = in_set[c] && row_valid[c] && (row_tag[c] == tag);
        end
    end

    // Lowest matching column wins.
    always_comb
    begin
        hit_col = '0;
        for (int c = 15; c >= 0; c--)
        begin
            if (hit_vec[c])
            begin
                hit_col = 4'(c);
            end
        end
    end

    // Pairwise tree: greatest age, ties go to the lower column.
    always_comb
    begin
        for (int l = 0; l < 5; l++)
        begin
            for (int i = 0; i < 16; i++)
            begin
                lkey[l][i] = '0;
                lidx[l][i] = '0;
            end
        end
        for (int c = 0; c < 16; c++)
        begin
            lkey[0][c] = {in_set[c], row_age[c]};
            lidx[0][c] = 4'(c);
        end
        for (int l = 0; l < 4; l++)
        begin
            for (int i = 0; i < (8 >> l); i++)
            begin
                if (lkey[l][2*i+1] > lkey[l][2*i])
                begin
                    lkey[l+1][i] = lkey[l][2*i+1];
                    lidx[l+1][i] = lidx[l][2*i+1];
                end
                else
                begin
                    lkey[l+1][i] = lkey[l][2*i];
                    lidx[l+1][i] = lidx[l][2*i];
                end
            end
        end
    end

    always_comb
    begin
        sel.hit = |hit_vec;
        sel.col = (|hit_vec) ? hit_col : lidx[4][0];
    end

endmodule

>>> rtl/set_assoc_cache_lru_lookup.sv
// Top level of the set-associative cache tag lookup with true LRU replacement.
//
//  Channel   Signals                                   Direction  Handshake
//  input     address, byte_count                       in         in_valid / in_ready
//  result    set_index, way, hit, last,                out        out_valid / out_ready
//            miss_total, hit_total
//  config    cfg_index, cfg_data                       in         cfg_write (no wait)
//
// Each touched block passes through a row read, a compare and victim search, then
// the age update and row write-back; an access of n blocks (n up to five) repeats
// these steps per block, and no new access is accepted until the last one is done.
// After reset and after every register write a clearing pass walks all
// CACHE_BYTES/64 rows (2048 rows by default), one row per cycle, with in_ready low.
// A result that is not taken holds the update stage until out_ready rises.
module set_assoc_cache_lru_lookup #(
    parameter int CACHE_BYTES = 131072
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [31:0]                         address,
    input  logic [4:0]                          byte_count,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [14:0]                         set_index,
    output logic [3:0]                          way,
    output logic                                hit,
    output logic                                last,
    output logic [15:0]                         miss_total,
    output logic [15:0]                         hit_total,
    input  logic                                cfg_write,
    input  logic [salru_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [salru_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int LOG_CB  = $clog2(CACHE_BYTES);
    localparam int ENTRY_W = LOG_CB - 2;
    localparam int ROWS    = CACHE_BYTES / 64;
    localparam int ROW_AW  = LOG_CB - 6;
    localparam int SL_MIN  = (LOG_CB > 9) ? LOG_CB - 9 : 0;
    localparam int TAG_W   = salru_pkg::BLK_W - SL_MIN;
    localparam int BLK_W   = salru_pkg::BLK_W;

    // Configuration registers and the geometry that follows from them.
    logic [2:0] ways_log2_reg;
    logic [1:0] burst_log2_reg;
    logic [2:0] eff_wl;
    logic [2:0] bsh;
    logic [3:0] need;
    logic [4:0] sl;
    logic [3:0] wmask;
    logic       cfg_hit;

    salru_pkg::state_t state_reg, state_next;

    logic [ROW_AW-1:0] clr_reg, clr_next;
    logic [BLK_W-1:0]  blk_reg, blk_next;
    logic [2:0]        left_reg, left_next;
    logic [14:0]       setidx_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [3:0]        col_reg;
    logic [ROW_AW-1:0] row_reg;
    salru_pkg::sel_t   sel_reg, sel_now;
    logic [15:0]       hit_count_reg, miss_count_reg;
    logic              out_valid_reg;
    logic [14:0]       set_index_reg;
    logic [3:0]        way_reg;
    logic              hit_reg;
    logic              last_reg;

    // Block decode.
    logic [BLK_W-1:0]   set_full;
    logic [ENTRY_W-1:0] base;
    logic [TAG_W-1:0]   blk_tag;

    // Access split.
    logic [4:0]  cnt_lim;
    logic [31:0] last_addr, first_blk32, last_blk32, bmask32, span;
    logic [2:0]  nblk;

    // Memory ports.
    logic                   ram_rd_en;
    logic                   ram_wr_en;
    logic [ROW_AW-1:0]      ram_wr_addr;
    logic [15:0][TAG_W-1:0] rd_tag, wr_tag;
    logic [15:0][3:0]       rd_age, wr_age;
    logic [15:0]            rd_valid, wr_valid;
    logic [3:0]             old_age;
    logic                   upd_go;
    logic                   in_accept;

    always_comb
    begin
        eff_wl = (ways_log2_reg > 3'(salru_pkg::WAY_LIMIT_LOG2))
               ? 3'(salru_pkg::WAY_LIMIT_LOG2) : ways_log2_reg;
        bsh    = {1'b0, burst_log2_reg} + 3'd2;
        need   = {1'b0, eff_wl} + {1'b0, bsh};
        if (5'(LOG_CB) > {1'b0, need})
        begin
            sl = 5'(LOG_CB) - {1'b0, need};
        end
        else
        begin
            sl = '0;
        end
        wmask   = 4'((5'd1 << eff_wl) - 5'd1);
        cfg_hit = cfg_write && ((cfg_index == salru_pkg::REG_WAYS_LOG2) ||
                                (cfg_index == salru_pkg::REG_BURST_LOG2));
    end

    // Set, tag and row position of the current block.
    always_comb
    begin
        set_full = blk_reg & ((BLK_W'(1) << sl) - BLK_W'(1));
        base     = ENTRY_W'(set_full) << eff_wl;
        blk_tag  = TAG_W'(blk_reg >> sl);
    end

    // Split of an access into blocks; at most five are looked up.
    always_comb
    begin
        cnt_lim     = (byte_count > 5'(salru_pkg::ACCESS_BYTE_LIMIT))
                    ? 5'(salru_pkg::ACCESS_BYTE_LIMIT) : byte_count;
        last_addr   = address + 32'(cnt_lim) - 32'd1;
        first_blk32 = address >> bsh;
        last_blk32  = last_addr >> bsh;
        bmask32     = 32'hFFFF_FFFF >> bsh;
        span        = (last_blk32 - first_blk32) & bmask32;
        nblk        = (span >= 32'(salru_pkg::RESULT_LIMIT - 1))
                    ? 3'(salru_pkg::RESULT_LIMIT) : span[2:0] + 3'd1;
    end

    assign in_ready  = (state_reg == salru_pkg::ST_IDLE) && !cfg_write;
    assign in_accept = in_valid && in_ready;
    assign upd_go    = (state_reg == salru_pkg::ST_UPD) && (!out_valid_reg || out_ready);
    assign ram_rd_en = (state_reg == salru_pkg::ST_READ);

    salru_row_ram #(
        .ROWS   (ROWS),
        .ROW_AW (ROW_AW),
        .TAG_W  (TAG_W)
    ) u_ram (
        .clk      (clk),
        .rd_en    (ram_rd_en),
        .rd_addr  (base[ENTRY_W-1:4]),
        .rd_tag   (rd_tag),
        .rd_age   (rd_age),
        .rd_valid (rd_valid),
        .wr_en    (ram_wr_en),
        .wr_addr  (ram_wr_addr),
        .wr_tag   (wr_tag),
        .wr_age   (wr_age),
        .wr_valid (wr_valid)
    );

    salru_way_sel #(
        .TAG_W (TAG_W)
    ) u_sel (
        .row_tag   (rd_tag),
        .row_age   (rd_age),
        .row_valid (rd_valid),
        .base_col  (col_reg),
        .wmask     (wmask),
        .tag       (tag_reg),
        .sel       (sel_now)
    );

    // Row write-back: either a clearing pass row or the updated set.
    always_comb
    begin
        old_age     = rd_age[sel_reg.col];
        ram_wr_en   = 1'b0;
        ram_wr_addr = row_reg;
        wr_tag      = rd_tag;
        wr_age      = rd_age;
        wr_valid    = rd_valid;
        if (state_reg == salru_pkg::ST_CLEAR)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_reg;
            wr_tag      = '0;
            wr_valid    = '0;
            for (int c = 0; c < 16; c++)
            begin
                wr_age[c] = 4'(c) & wmask;
            end
        end
        else if (upd_go)
        begin
            ram_wr_en = 1'b1;
            for (int c = 0; c < 16; c++)
            begin
                if ((4'(c) & ~wmask) == (col_reg & ~wmask))
                begin
                    if (4'(c) == sel_reg.col)
                    begin
                        wr_age[c] = 4'd0;
                    end
                    else if (rd_age[c] < old_age)
                    begin
                        wr_age[c] = rd_age[c] + 4'd1;
                    end
                end
            end
            if (!sel_reg.hit)
            begin
                wr_tag[sel_reg.col]   = tag_reg;
                wr_valid[sel_reg.col] = 1'b1;
            end
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        blk_next   = blk_reg;
        left_next  = left_reg;
        case (state_reg)
            salru_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + ROW_AW'(1);
                if (clr_reg == ROW_AW'(ROWS - 1))
                begin
                    state_next = salru_pkg::ST_IDLE;
                end
            end
            salru_pkg::ST_IDLE:
            begin
                if (in_accept && (cnt_lim != 5'd0))
                begin
                    blk_next   = first_blk32[BLK_W-1:0];
                    left_next  = nblk;
                    state_next = salru_pkg::ST_READ;
                end
            end
            salru_pkg::ST_READ:
            begin
                state_next = salru_pkg::ST_CMP;
            end
            salru_pkg::ST_CMP:
            begin
                state_next = salru_pkg::ST_UPD;
            end
            salru_pkg::ST_UPD:
            begin
                if (upd_go)
                begin
                    left_next = left_reg - 3'd1;
                    blk_next  = (blk_reg + BLK_W'(1)) & bmask32[BLK_W-1:0];
                    if (left_reg == 3'd1)
                    begin
                        state_next = salru_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = salru_pkg::ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = salru_pkg::ST_CLEAR;
            end
        endcase
        // A register write restarts the clearing pass under the new geometry.
        if (cfg_hit)
        begin
            state_next = salru_pkg::ST_CLEAR;
            clr_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= salru_pkg::ST_CLEAR;
            clr_reg        <= '0;
            left_reg       <= '0;
            ways_log2_reg  <= 3'd3;
            burst_log2_reg <= 2'd0;
            hit_count_reg  <= '0;
            miss_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            left_reg  <= left_next;
            if (cfg_write && (cfg_index == salru_pkg::REG_WAYS_LOG2))
            begin
                ways_log2_reg <= cfg_data;
            end
            if (cfg_write && (cfg_index == salru_pkg::REG_BURST_LOG2))
            begin
                burst_log2_reg <= cfg_data[1:0];
            end
            if (upd_go)
            begin
                out_valid_reg <= 1'b1;
                if (sel_reg.hit)
                begin
                    hit_count_reg <= hit_count_reg + 16'd1;
                end
                else
                begin
                    miss_count_reg <= miss_count_reg + 16'd1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        if (state_reg == salru_pkg::ST_READ)
        begin
            setidx_reg <= set_full[14:0];
            tag_reg    <= blk_tag;
            col_reg    <= base[3:0];
            row_reg    <= base[ENTRY_W-1:4];
        end
        if (state_reg == salru_pkg::ST_CMP)
        begin
            sel_reg <= sel_now;
        end
        if (upd_go)
        begin
            set_index_reg <= setidx_reg;
            way_reg       <= sel_reg.col & wmask;
            hit_reg       <= sel_reg.hit;
            last_reg      <= (left_reg == 3'd1);
        end
    end

    assign out_valid  = out_valid_reg;
    assign set_index  = set_index_reg;
    assign way        = way_reg;
    assign hit        = hit_reg;
    assign last       = last_reg;
    assign miss_total = miss_count_reg;
    assign hit_total  = hit_count_reg;

    // Every block result moves exactly one of the two totals by one.
    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        upd_go |=> 16'(hit_count_reg + miss_count_reg) ==
                   16'($past(hit_count_reg) + $past(miss_count_reg) + 16'd1))
        else $error("totals did not advance by one block");

    // The round trip never reads and writes the rows in the same cycle.
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_rd_en && ram_wr_en))
        else $error("row read and write in the same cycle");

    // A hit is only ever taken on a valid way.
    a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == salru_pkg::ST_UPD && sel_reg.hit) |-> rd_valid[sel_reg.col])
        else $error("hit on an invalid way");

    // The last result of an access returns the sequencer to idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_go && left_reg == 3'd1 && !cfg_hit) |=> state_reg == salru_pkg::ST_IDLE)
        else $error("sequencer did not return to idle after last block");

endmodule

>>> dv/set_assoc_cache_lru_lookup_tb.sv
// Self-checking testbench for the set-associative LRU cache tag lookup.
`timescale 1ns / 1ps

module set_assoc_cache_lru_lookup_tb;

    localparam int ENTRIES   = 32768;
    localparam int WDOG_MAX  = 20000;
    localparam int SETTLE    = 40;

    typedef struct packed {
        logic [31:0] address;
        logic [4:0]  byte_count;
    } access_t;

    typedef struct packed {
        logic [14:0] set_index;
        logic [3:0]  way;
        logic        hit;
        logic        last;
        logic [15:0] miss_total;
        logic [15:0] hit_total;
    } lookup_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] address;
    logic [4:0]  byte_count;
    logic        out_valid;
    logic        out_ready;
    logic [14:0] set_index;
    logic [3:0]  way;
    logic        hit;
    logic        last;
    logic [15:0] miss_total;
    logic [15:0] hit_total;
    logic        cfg_write;
    logic [salru_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [salru_pkg::CFG_DATA_W-1:0] cfg_data;

    // Shadow copy of the tag store and configuration.
    logic [31:0] tag_mem [ENTRIES];
    logic [3:0]  age_mem [ENTRIES];
    logic        vld_mem [ENTRIES];
    logic [15:0] misses;
    logic [15:0] hits;
    logic [2:0]  cur_ways_log2;
    logic [1:0]  cur_burst_log2;

    access_t pending_accesses[$];
    lookup_t expected_lookups[$];

    int  mismatches;
    int  wdog;
    bit  calm;       // when set, neither side idles
    bit  in_taken;   // the input transaction was accepted at the last rising edge

    set_assoc_cache_lru_lookup i_dut (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int eff_ways_log2();
        return (cur_ways_log2 > salru_pkg::WAY_LIMIT_LOG2)
             ? salru_pkg::WAY_LIMIT_LOG2 : int'(cur_ways_log2);
    endfunction

    // Clear valid bits and restore ages; a register write does this under the new geometry.
    task automatic reset_store();
        int wmask;
        wmask = (1 << eff_ways_log2()) - 1;
        for (int e = 0; e < ENTRIES; e++)
        begin
            vld_mem[e] = 1'b0;
            tag_mem[e] = '0;
            age_mem[e] = 4'(e & wmask);
        end
    endtask

    // Work out the block lookups caused by one access and queue them.
    task automatic predict_lookups(input access_t acc);
        longint unsigned amask, a, cnt, bmask, first, lastb, nblk, blk;
        int wl, ways, sl, bsh, base, pick, e;
        int unsigned setn, tg, best, prior;
        bit found;
        lookup_t r;
        amask = 64'hFFFF_FFFF;
        a = acc.address;
        cnt = acc.byte_count;
        wl = eff_ways_log2();
        ways = 1 << wl;
        bsh = cur_burst_log2 + 2;
        sl = (17 > wl + bsh) ? 17 - (wl + bsh) : 0;
        if (cnt > salru_pkg::ACCESS_BYTE_LIMIT)
            cnt = salru_pkg::ACCESS_BYTE_LIMIT;
        if (cnt == 0)
            return;
        bmask = amask >> bsh;
        first = a >> bsh;
        lastb = ((a + cnt - 1) & amask) >> bsh;
        nblk = ((lastb - first) & bmask) + 1;
        if (nblk > salru_pkg::RESULT_LIMIT)
            nblk = salru_pkg::RESULT_LIMIT;
        for (longint unsigned k = 0; k < nblk; k++)
        begin
            blk = (first + k) & bmask;
            setn = int'(blk & ((64'd1 << sl) - 1));
            tg = int'(blk >> sl);
            base = int'((setn << wl) % ENTRIES);
            found = 0;
            pick = 0;
            for (int w = 0; w < ways && !found; w++)
            begin
                e = (base + w) % ENTRIES;
                if (vld_mem[e] && tag_mem[e] == tg)
                begin
                    found = 1;
                    pick = w;
                end
            end
            if (found)
                hits++;
            else
            begin
                best = 0;
                for (int w = 0; w < ways; w++)
                begin
                    e = (base + w) % ENTRIES;
                    if (w == 0 || age_mem[e] > best)
                    begin
                        best = age_mem[e];
                        pick = w;
                    end
                end
                tag_mem[(base + pick) % ENTRIES] = tg;
                vld_mem[(base + pick) % ENTRIES] = 1'b1;
                misses++;
            end
            prior = age_mem[(base + pick) % ENTRIES];
            for (int w = 0; w < ways; w++)
            begin
                e = (base + w) % ENTRIES;
                if (age_mem[e] < prior)
                    age_mem[e] = age_mem[e] + 4'd1;
            end
            age_mem[(base + pick) % ENTRIES] = 4'd0;
            r.set_index  = 15'(setn);
            r.way        = 4'(pick);
            r.hit        = found;
            r.last       = (k + 1 == nblk);
            r.miss_total = misses;
            r.hit_total  = hits;
            expected_lookups.push_back(r);
        end
    endtask

    // Driver: one transaction at a time from the pending queue, changes on the falling edge.
    // A new transaction is offered only once the previous one was taken at a rising edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (pending_accesses.size() > 0 && (calm || $urandom_range(99) >= 15))
                begin
                    access_t nx;
                    nx = pending_accesses.pop_front();
                    predict_lookups(nx);
                    in_valid   <= 1'b1;
                    address    <= nx.address;
                    byte_count <= nx.byte_count;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= calm || ($urandom_range(99) >= 15);
        end
    end

    // Acceptance on both channels is judged from values sampled at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;
            if ((in_valid && in_ready) || (out_valid && out_ready))
                wdog <= 0;
            else
                wdog <= wdog + 1;
            if (out_valid && out_ready)
            begin
                if (expected_lookups.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result transaction: set %0d way %0d",
                            set_index, way);
                end
                else
                begin
                    lookup_t x;
                    x = expected_lookups.pop_front();
                    if (x !== {set_index, way, hit, last, miss_total, hit_total})
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("Result mismatch: exp set %0d way %0d hit %0d last %0d",
                                x.set_index, x.way, x.hit, x.last);
                            $display("    exp miss %0d hit_t %0d", x.miss_total, x.hit_total);
                            $display("    got set %0d way %0d hit %0d last %0d",
                                set_index, way, hit, last);
                            $display("    got miss %0d hit_t %0d", miss_total, hit_total);
                        end
                    end
                end
            end
            if (wdog >= WDOG_MAX)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Write one register while the block is idle; the shadow store follows the block.
    task automatic write_reg(input logic [salru_pkg::CFG_IDX_W-1:0] idx,
                             input logic [2:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == salru_pkg::REG_WAYS_LOG2)
            cur_ways_log2 = val;
        else
            cur_burst_log2 = val[1:0];
        reset_store();
    endtask

    // Wait until every queued transaction has gone in and every result has come back.
    task automatic drain();
        while (pending_accesses.size() > 0 || in_valid || expected_lookups.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic add_access(input logic [31:0] a, input logic [4:0] n);
        access_t t;
        t.address = a;
        t.byte_count = n;
        pending_accesses.push_back(t);
    endtask

    // Random accesses mostly kept to a small address window, so sets are revisited and hits occur.
    task automatic random_phase(input int n);
        logic [31:0] a;
        logic [31:0] pool;
        pool = $urandom();
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0, 1:    a = $urandom();
                2:       a = 32'hFFFF_FFF0 | $urandom_range(15);
                default: a = pool + ($urandom_range(4095) << $urandom_range(17));
            endcase
            add_access(a, 5'($urandom_range(31)));
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        out_ready  = 1'b0;
        address    = '0;
        byte_count = '0;
        cfg_write  = 1'b0;
        cfg_index  = salru_pkg::REG_WAYS_LOG2;
        cfg_data   = '0;
        mismatches = 0;
        wdog       = 0;
        calm       = 1'b0;
        in_taken   = 1'b0;
        misses     = '0;
        hits       = '0;
        cur_ways_log2  = 3'd3;
        cur_burst_log2 = 2'd0;
        reset_store();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under reset geometry: extremes, zero and oversize counts, wrap.
        add_access(32'h0000_0000, 5'd1);
        add_access(32'h0000_0000, 5'd4);
        add_access(32'h0000_0003, 5'd16);
        add_access(32'h0000_0002, 5'd0);
        add_access(32'h0000_0001, 5'd31);
        add_access(32'hFFFF_FFFF, 5'd1);
        add_access(32'hFFFF_FFFE, 5'd16);
        add_access(32'hAAAA_5555, 5'd17);
        add_access(32'h5555_AAAA, 5'd8);
        // Ten tags into set zero overflow eight ways and force an LRU eviction.
        for (int t = 0; t < 10; t++)
            add_access(32'(t) << 14, 5'd1);
        add_access(32'h0000_0000, 5'd2);
        drain();

        // Walk the geometries, with both extremes of each register.
        for (int ph = 0; ph < 8; ph++)
        begin
            logic [2:0] wv;
            logic [1:0] bv;
            case (ph)
                0: begin wv = 3'd0; bv = 2'd0; end
                1: begin wv = 3'd4; bv = 2'd3; end
                2: begin wv = 3'd7; bv = 2'd1; end
                3: begin wv = 3'd5; bv = 2'd2; end
                default: begin wv = 3'($urandom_range(7)); bv = 2'($urandom_range(3)); end
            endcase
            write_reg(salru_pkg::REG_WAYS_LOG2, wv);
            write_reg(salru_pkg::REG_BURST_LOG2, bv);
            calm = (ph == 3);
            random_phase(35);
            drain();
        end

        if (mismatches == 0 && expected_lookups.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
